FILE: hdl/ucbd_pkg.sv
package ucbd_pkg;

  localparam int VALUE_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       byte_is_last;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] decoded_value;
    logic               overflow;
    logic               incomplete;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_UNARY,
    PH_READ,
    PH_EXTRA,
    PH_NFLAG,
    PH_NDATA
  } phase_t;

  localparam logic [2:0] KIND_UNARY  = 3'd0;
  localparam logic [2:0] KIND_GAMMA  = 3'd1;
  localparam logic [2:0] KIND_ZETA   = 3'd2;
  localparam logic [2:0] KIND_NIBBLE = 3'd3;
  localparam logic [2:0] KIND_FIXED  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_KIND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZETA_K      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_WIDTH = 2'd2;

  localparam logic [2:0] CODE_KIND_RST   = KIND_GAMMA;
  localparam logic [3:0] ZETA_K_RST      = 4'd3;
  localparam logic [6:0] FIXED_WIDTH_RST = 7'd8;

endpackage

FILE: hdl/ucbd_fifo.sv
module ucbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hdl/ucbd_back.sv
module ucbd_back #(
  parameter int VALUE_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ucbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ucbd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  input  ucbd_pkg::in_item_t                 in_item,
  output logic                               in_take,
  output logic                               res_push,
  output ucbd_pkg::out_item_t                res_item,
  input  logic                               res_full
);
  import ucbd_pkg::*;

  localparam logic [31:0] UnaryLim =
    (VALUE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_BITS) - 64'd1);

  logic [2:0]  code_kind_r;
  logic [3:0]  zeta_k_r;
  logic [6:0]  fixed_width_r;

  logic [7:0]  byte_r;
  logic        last_r;
  logic        busy_r, busy_nxt;
  logic [2:0]  bit_idx_r, bit_idx_nxt;

  phase_t                phase_r, ph_w;
  logic [31:0]           zero_run_r, zr_w;
  logic [VALUE_BITS-1:0] accum_r, acc_w;
  logic [6:0]            btr_r, btr_w;
  logic                  nstop_r, nst_w;
  logic                  ehold_r, eh_w;

  logic      pend_v_r, pend_v_nxt;
  out_item_t pend_r, pend_nxt;

  logic                  step, byte_end, live, kill, bit_w, cfg_hit;
  logic                  res_v, res_ovf, res_inc;
  logic [VALUE_BITS-1:0] res_val, acc_n, left, one_w;
  logic [3:0]            k_eff;
  logic [6:0]            fw_eff;
  logic [11:0]           sh12, cnt12, zchk12;

  assign step     = busy_r & ~res_full;
  assign byte_end = step & (bit_idx_r == 3'd0);
  assign in_take  = in_valid & (~busy_r | byte_end);
  assign bit_w    = byte_r[bit_idx_r];
  assign cfg_hit  = cfg_we & ((cfg_index == REG_CODE_KIND) | (cfg_index == REG_ZETA_K) |
                              (cfg_index == REG_FIXED_WIDTH));

  assign k_eff  = (zeta_k_r == 4'd0) ? 4'd1 : zeta_k_r;
  assign fw_eff = (fixed_width_r == 7'd0) ? 7'd1 :
                  (fixed_width_r > 7'd64) ? 7'd64 : fixed_width_r;
  assign sh12   = {5'b0, zero_run_r[6:0]} * {8'b0, k_eff};
  assign cnt12  = sh12 + {8'b0, k_eff} - 12'd1;
  assign zchk12 = sh12 + {7'b0, k_eff, 1'b0};
  assign one_w  = {{(VALUE_BITS-1){1'b0}}, 1'b1};
  assign left   = one_w << sh12[5:0];
  assign acc_n  = {accum_r[VALUE_BITS-2:0], bit_w};

  always_comb begin
    ph_w    = phase_r;
    zr_w    = zero_run_r;
    acc_w   = accum_r;
    btr_w   = btr_r;
    nst_w   = nstop_r;
    eh_w    = ehold_r;
    res_v   = 1'b0;
    res_ovf = 1'b0;
    res_inc = 1'b0;
    res_val = '0;
    kill    = 1'b0;
    live    = 1'b0;
    if (step && !ehold_r) begin
      live = 1'b1;
      if (phase_r == PH_IDLE) begin
        case (code_kind_r)
          KIND_UNARY, KIND_GAMMA, KIND_ZETA: ph_w = PH_UNARY;
          KIND_NIBBLE: ph_w = PH_NFLAG;
          KIND_FIXED: begin
            ph_w  = PH_READ;
            btr_w = fw_eff;
          end
          default: live = 1'b0;
        endcase
      end
    end
    if (live) begin
      case (ph_w)
        PH_UNARY: begin
          if (bit_w) begin
            case (code_kind_r)
              KIND_UNARY: begin
                res_v   = 1'b1;
                res_val = VALUE_BITS'(zero_run_r);
              end
              KIND_GAMMA: begin
                if (zero_run_r == '0) begin
                  res_v = 1'b1;
                end else begin
                  acc_w = one_w;
                  btr_w = zero_run_r[6:0];
                  ph_w  = PH_READ;
                end
              end
              default: begin
                if (cnt12 == '0) begin
                  res_v = 1'b1;
                end else begin
                  acc_w = '0;
                  btr_w = cnt12[6:0];
                  ph_w  = PH_READ;
                end
              end
            endcase
          end else begin
            case (code_kind_r)
              KIND_UNARY: res_ovf = (zero_run_r >= UnaryLim);
              KIND_GAMMA: res_ovf = (({1'b0, zero_run_r} + 33'd1) >= 33'(VALUE_BITS));
              default:    res_ovf = (zchk12 > 12'(VALUE_BITS));
            endcase
            if (res_ovf) begin
              res_v = 1'b1;
            end else begin
              zr_w = zero_run_r + 32'd1;
            end
          end
        end
        PH_READ: begin
          if (code_kind_r == KIND_FIXED && accum_r[VALUE_BITS-1]) begin
            res_v   = 1'b1;
            res_ovf = 1'b1;
          end else begin
            acc_w = acc_n;
            if (btr_w != '0) begin
              btr_w = btr_w - 7'd1;
            end
            if (btr_w == '0) begin
              case (code_kind_r)
                KIND_GAMMA: begin
                  res_v   = 1'b1;
                  res_val = acc_n - one_w;
                end
                KIND_ZETA: begin
                  if (acc_n < left) begin
                    res_v   = 1'b1;
                    res_val = acc_n + left - one_w;
                  end else begin
                    ph_w = PH_EXTRA;
                  end
                end
                default: begin
                  res_v   = 1'b1;
                  res_val = acc_n;
                end
              endcase
            end
          end
        end
        PH_EXTRA: begin
          res_v   = 1'b1;
          res_val = {accum_r[VALUE_BITS-2:0], 1'b0} + {{(VALUE_BITS-1){1'b0}}, bit_w} - one_w;
        end
        PH_NFLAG: begin
          if (accum_r[VALUE_BITS-1 -: 3] != 3'd0) begin
            res_v   = 1'b1;
            res_ovf = 1'b1;
          end else begin
            nst_w = bit_w;
            acc_w = accum_r << 3;
            btr_w = 7'd3;
            ph_w  = PH_NDATA;
          end
        end
        PH_NDATA: begin
          if (btr_w != '0) begin
            btr_w = btr_w - 7'd1;
          end
          acc_w = accum_r | ({{(VALUE_BITS-1){1'b0}}, bit_w} << btr_w[1:0]);
          if (btr_w == '0) begin
            if (nstop_r) begin
              res_v   = 1'b1;
              res_val = acc_w;
            end else begin
              ph_w = PH_NFLAG;
            end
          end
        end
        default: kill = 1'b1;
      endcase
    end
    if (res_ovf) begin
      res_val = '0;
      eh_w    = 1'b1;
    end
    if (res_v || kill) begin
      ph_w  = PH_IDLE;
      zr_w  = '0;
      acc_w = '0;
      btr_w = '0;
      nst_w = 1'b0;
    end
    // flag a partly read codeword at end of stream, then drop everything
    if (byte_end && last_r) begin
      if (!eh_w && ph_w != PH_IDLE) begin
        res_v   = 1'b1;
        res_inc = 1'b1;
        res_val = '0;
      end
      ph_w  = PH_IDLE;
      zr_w  = '0;
      acc_w = '0;
      btr_w = '0;
      nst_w = 1'b0;
      eh_w  = 1'b0;
    end
    if (cfg_hit) begin
      ph_w  = PH_IDLE;
      zr_w  = '0;
      acc_w = '0;
      btr_w = '0;
      nst_w = 1'b0;
    end
  end

  // hold the newest result until the next one, or the end of its byte, shows whether it is last
  assign res_push = pend_v_r & ~res_full & (pend_r.last_of_run | res_v);
  assign res_item = pend_r;

  always_comb begin
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (res_v) begin
      pend_v_nxt             = 1'b1;
      pend_nxt.decoded_value = VALUE_W'(res_val);
      pend_nxt.overflow      = res_ovf;
      pend_nxt.incomplete    = res_inc;
      pend_nxt.last_of_run   = byte_end;
    end else if (res_push) begin
      pend_v_nxt = 1'b0;
    end else if (byte_end && pend_v_r) begin
      pend_nxt.last_of_run = 1'b1;
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    bit_idx_nxt = bit_idx_r;
    if (step) begin
      bit_idx_nxt = bit_idx_r - 3'd1;
    end
    if (in_take) begin
      busy_nxt    = 1'b1;
      bit_idx_nxt = 3'd7;
    end else if (byte_end) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_kind_r   <= CODE_KIND_RST;
      zeta_k_r      <= ZETA_K_RST;
      fixed_width_r <= FIXED_WIDTH_RST;
      busy_r        <= 1'b0;
      bit_idx_r     <= '0;
      phase_r       <= PH_IDLE;
      zero_run_r    <= '0;
      accum_r       <= '0;
      btr_r         <= '0;
      nstop_r       <= 1'b0;
      ehold_r       <= 1'b0;
      pend_v_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CODE_KIND:   code_kind_r   <= cfg_data[2:0];
          REG_ZETA_K:      zeta_k_r      <= cfg_data[3:0];
          REG_FIXED_WIDTH: fixed_width_r <= cfg_data;
          default:         ;
        endcase
      end
      busy_r     <= busy_nxt;
      bit_idx_r  <= bit_idx_nxt;
      phase_r    <= ph_w;
      zero_run_r <= zr_w;
      accum_r    <= acc_w;
      btr_r      <= btr_w;
      nstop_r    <= nst_w;
      ehold_r    <= eh_w;
      pend_v_r   <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (in_take) begin
      byte_r <= in_item.stream_byte;
      last_r <= in_item.byte_is_last;
    end
  end

endmodule

FILE: hdl/universal_code_bit_decoder_core.sv
// Decodes unary, Elias gamma, zeta(k), nibble and fixed width integer codes from a byte
// stream, msb first, one request per byte; each finished codeword gives one result and the
// final result of a byte carries last_of_run. Bytes wait in a short input queue, results in
// a short output queue. The decode engine works one stream bit per clock while the
// output queue has room, so bytes follow back to back while the output side keeps up;
// a result leaves the engine in the cycle the next codeword of its byte ends or, if it
// is its byte's last, once last_of_run is registered at byte end and the queue has room.
// Configuration writes drop any partly read codeword and are meant for an idle block.
module universal_code_bit_decoder_core #(
  parameter int VALUE_BITS = 64,
  parameter int IN_DEPTH   = 2,
  parameter int OUT_DEPTH  = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  ucbd_pkg::in_item_t              in_item,
  output logic                            empty,
  input  logic                            pop,
  output ucbd_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [ucbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ucbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ucbd_pkg::*;

  logic      inq_empty, back_take, res_push, res_full;
  in_item_t  inq_item;
  out_item_t res_item;

  ucbd_fifo #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_inq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (back_take),
    .rdata (inq_item),
    .empty (inq_empty)
  );

  ucbd_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (~inq_empty),
    .in_item   (inq_item),
    .in_take   (back_take),
    .res_push  (res_push),
    .res_item  (res_item),
    .res_full  (res_full)
  );

  ucbd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

endmodule

FILE: hdl/ucbd_checker.sv
module ucbd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input ucbd_pkg::out_item_t out_item
);
  import ucbd_pkg::*;

  a_flagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.overflow || out_item.incomplete)) |-> (out_item.decoded_value == '0))
    else $error("flagged result carries a non-zero value");

  a_flags_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_item.overflow && out_item.incomplete))
    else $error("overflow and incomplete on the same result");

  a_incomplete_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.incomplete) |-> out_item.last_of_run)
    else $error("incomplete result not marked last of its byte");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

endmodule

bind universal_code_bit_decoder_core ucbd_checker u_ucbd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);
